// File: src/lbs_pkg.sv
// Package for the linear blend vertex skinning block.
// Holds request and result types and fixed constants; no dependencies.
package lbs_pkg;

    localparam int unsigned WordsPerJoint = 12;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_SKIN  = 1'b1
    } t_op;

    typedef struct packed {
        logic        op;
        logic [11:0] entry_addr;
        logic signed [31:0] entry_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0] joint_ids;
        logic [31:0] weights;
    } t_req;

    typedef struct packed {
        logic signed [31:0] skinned_x;
        logic signed [31:0] skinned_y;
        logic signed [31:0] skinned_z;
        logic        was_skinned;
    } t_res;

    // One task for the back end: a palette write or one influence of a vertex.
    typedef struct packed {
        logic        is_write;
        logic [11:0] addr;
        logic [31:0] wdata;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [7:0]  joint;
        logic [7:0]  weight;
        logic        used;
        logic        first;
        logic        last;
        logic        any;
    } t_task;

endpackage

// File: src/lbs_if.sv
// Valid/ready channel interface for the skinning block.
// Depends on lbs_pkg for nothing; payload type is a parameter.
interface lbs_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/linear_blend_vertex_skinning.sv
// Top level of linear blend vertex skinning: front end, queue, back end.
// Depends on lbs_pkg, lbs_if, lbs_front, lbs_fifo, lbs_back.
//
//  channel  | dir | payload           | accepted when
//  i_req    | in  | lbs_pkg::t_req    | valid && ready
//  o_res    | out | lbs_pkg::t_res    | valid && ready
//  cfg      | in  | joint limit (9b)  | i_cfg_we
//
// A palette write is one task; a vertex becomes INFLUENCES tasks, one per
// influence through the single palette read port and row-transform unit.
// Reset is synchronous and clears control state only. A stalled result holds
// the whole back end; the two-entry queue absorbs the front end's work
// meanwhile and then holds off the input.
module linear_blend_vertex_skinning #(
    parameter int unsigned MAX_JOINTS = 256,
    parameter int unsigned INFLUENCES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_wdata,
    lbs_if.sink        i_req,
    lbs_if.source      o_res
);
    logic [8:0] r_num_joints;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_joints <= 9'd0;
        end else if (i_cfg_we) begin
            r_num_joints <= i_cfg_wdata;
        end
    end

    logic f_valid, f_ready, q_valid, q_ready;
    lbs_pkg::t_task f_task, q_task;

    lbs_front #(.INFLUENCES(INFLUENCES), .MAX_JOINTS(MAX_JOINTS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_req.valid), .o_ready(i_req.ready), .i_req(i_req.data),
        .i_num_joints(r_num_joints),
        .o_valid(f_valid), .i_ready(f_ready), .o_task(f_task)
    );

    lbs_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_task),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_task)
    );

    lbs_back #(.MAX_JOINTS(MAX_JOINTS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_task(q_task),
        .o_valid(o_res.valid), .i_ready(o_res.ready), .o_res(o_res.data)
    );
endmodule

// File: src/lbs_front.sv
// Front end: takes requests and splits a vertex into one task per influence.
// Depends on lbs_pkg.
module lbs_front #(
    parameter int unsigned INFLUENCES = 4,
    parameter int unsigned MAX_JOINTS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lbs_pkg::t_req i_req,
    input  logic [8:0]    i_num_joints,
    output logic          o_valid,
    input  logic          i_ready,
    output lbs_pkg::t_task o_task
);
    localparam int unsigned KW = (INFLUENCES > 1) ? $clog2(INFLUENCES) : 1;

    logic [KW-1:0] r_k, n_k;
    logic [1:0]    w_sel;
    logic [7:0]    w_id, w_wt;
    logic          w_last, w_any;
    logic [8:0]    w_limit;

    always_comb begin
        w_sel = 2'(r_k);
        w_id = 8'd0;
        w_wt = 8'd0;
        if ({{(32-KW){1'b0}}, r_k} < 32'd4) begin
            w_id = i_req.joint_ids[{w_sel, 3'b000} +: 8];
            w_wt = i_req.weights[{w_sel, 3'b000} +: 8];
        end
        // Only the bytes of influences that exist count toward skinning.
        w_any = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (k < INFLUENCES && i_req.weights[8*k +: 8] != 8'd0) begin
                w_any = 1'b1;
            end
        end
        w_last = (i_req.op == lbs_pkg::OP_WRITE) || (r_k == KW'(INFLUENCES - 1));
        w_limit = (i_num_joints > 9'(MAX_JOINTS)) ? 9'(MAX_JOINTS) : i_num_joints;
    end

    assign o_valid = i_valid;
    assign o_ready = i_ready && w_last;

    always_comb begin
        o_task.is_write = (i_req.op == lbs_pkg::OP_WRITE);
        o_task.addr     = i_req.entry_addr;
        o_task.wdata    = i_req.entry_value;
        o_task.pos_x    = i_req.pos_x;
        o_task.pos_y    = i_req.pos_y;
        o_task.pos_z    = i_req.pos_z;
        o_task.joint    = w_id;
        o_task.weight   = w_wt;
        o_task.used     = (w_wt != 8'd0) && ({1'b0, w_id} < w_limit);
        o_task.first    = (r_k == '0);
        o_task.last     = w_last;
        o_task.any      = w_any;
    end

    always_comb begin
        n_k = r_k;
        if (i_valid && i_ready) begin
            n_k = w_last ? '0 : r_k + KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else begin
            r_k <= n_k;
        end
    end
endmodule

// File: src/lbs_fifo.sv
// Short queue between the front and back ends.
// Depends on lbs_pkg.
module lbs_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lbs_pkg::t_task i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output lbs_pkg::t_task o_data
);
    lbs_pkg::t_task r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// File: src/lbs_back.sv
// Back end: palette memory, row transforms, weighted sum, divide by 255.
// Depends on lbs_pkg.
module lbs_back #(
    parameter int unsigned MAX_JOINTS = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lbs_pkg::t_task i_task,
    output logic           o_valid,
    input  logic           i_ready,
    output lbs_pkg::t_res  o_res
);
    localparam int unsigned Words = MAX_JOINTS * lbs_pkg::WordsPerJoint;
    localparam int unsigned NS = 6;
    localparam logic signed [61:0] SatBound = 62'sh7F_8000_0000;

    // Per-lane word memories: lane r*4+c holds row r, column c, indexed by joint.
    logic [31:0] r_pal [12][MAX_JOINTS];

    logic [NS-1:0] r_v;
    logic w_adv;
    assign w_adv = !r_v[NS-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v[NS-1];

    logic w_take;
    assign w_take = i_valid && w_adv;

    // Write decode: addr = joint*12 + lane.
    logic [11:0] w_j12;
    logic [3:0]  w_lane;
    always_comb begin
        w_j12 = 12'((24'(i_task.addr) * 24'd2731) >> 15);
        w_lane = 4'(i_task.addr - w_j12 * 12'd12);
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_task.is_write && ({20'd0, i_task.addr} < Words)) begin
            r_pal[w_lane][w_j12[7:0]] <= i_task.wdata;
        end
    end

    // Stage 1: memory read.
    lbs_pkg::t_task r_t1, r_t2, r_t3, r_t4, r_t5;
    logic [31:0] r_m [12];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t1 <= i_task;
            for (int i = 0; i < 12; i++) begin
                r_m[i] <= r_pal[i][i_task.joint];
            end
        end
    end

    // Stage 2: nine products.
    logic signed [63:0] r_p [9];
    logic signed [31:0] r_c [3];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t2 <= r_t1;
            for (int r = 0; r < 3; r++) begin
                r_p[r*3]   <= $signed(r_m[r*4])   * r_t1.pos_x;
                r_p[r*3+1] <= $signed(r_m[r*4+1]) * r_t1.pos_y;
                r_p[r*3+2] <= $signed(r_m[r*4+2]) * r_t1.pos_z;
                r_c[r] <= $signed(r_m[r*4+3]);
            end
        end
    end

    // Stage 3: row sum; floor of total equals sum of floors plus carries.
    logic signed [50:0] r_row [3];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t3 <= r_t2;
            for (int r = 0; r < 3; r++) begin
                r_row[r] <= 51'((66'(r_p[r*3]) + 66'(r_p[r*3+1]) + 66'(r_p[r*3+2]))
                    >>> 16) + 51'(r_c[r]);
            end
        end
    end

    // Stage 4: weight and accumulate over influences.
    logic signed [61:0] r_acc [3];
    logic signed [61:0] w_acc [3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_acc[r] = r_t3.first ? 62'sd0 : r_acc[r];
            if (r_t3.used) begin
                w_acc[r] = w_acc[r] + 62'(r_row[r]) * 62'($signed({1'b0, r_t3.weight}));
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv && r_v[2]) begin
            r_t4 <= r_t3;
            for (int r = 0; r < 3; r++) r_acc[r] <= w_acc[r];
        end
    end

    // Stage 5: flag sums whose quotient leaves 32 bits, and bias the rest to a
    // nonnegative value below 2^40.
    logic [39:0] r_b [3];
    logic [2:0]  r_hi, r_lo;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t5 <= r_t4;
            for (int r = 0; r < 3; r++) begin
                r_hi[r] <= (r_acc[r] >= SatBound);
                r_lo[r] <= (r_acc[r] < -SatBound);
                r_b[r]  <= 40'(r_acc[r] + SatBound);
            end
        end
    end

    // Stage 6: floor(b/255) is (b * 0x010101010102) >> 48 for b below 2^40;
    // removing the bias of 2^31 flips the top bit of the quotient.
    lbs_pkg::t_res r_out;
    logic [80:0] w_prod [3];
    logic signed [31:0] w_s [3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_prod[r] = (81'(r_b[r]) << 40) + (81'(r_b[r]) << 32) + (81'(r_b[r]) << 24)
                + (81'(r_b[r]) << 16) + (81'(r_b[r]) << 8) + (81'(r_b[r]) << 1);
            if (r_hi[r]) w_s[r] = 32'sh7fffffff;
            else if (r_lo[r]) w_s[r] = 32'sh80000000;
            else w_s[r] = {~w_prod[r][79], w_prod[r][78:48]};
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.was_skinned <= r_t5.any;
            r_out.skinned_x <= r_t5.any ? w_s[0] : r_t5.pos_x;
            r_out.skinned_y <= r_t5.any ? w_s[1] : r_t5.pos_y;
            r_out.skinned_z <= r_t5.any ? w_s[2] : r_t5.pos_z;
        end
    end
    assign o_res = r_out;

    // Valid chain; only a vertex's last influence produces a result.
    logic w_v4;
    assign w_v4 = r_v[3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v[0] <= w_take && !i_task.is_write;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2] && r_t3.last;
            r_v[4] <= w_v4;
            r_v[5] <= r_v[4];
        end
    end
endmodule
